### rtl/pfc_pkg.sv
// Shared types, format codes and constants for the pixel format converter.
package pfc_pkg;

   localparam int unsigned WORD_W      = 64;
   localparam int unsigned FMT_W       = 3;
   localparam int unsigned NBYTES_W    = 4;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned OUT_DEPTH   = 2;
   localparam int unsigned DIV_STAGES  = 8;

   localparam logic [FMT_W-1:0] FMT_RGBA16P = 3'd0;
   localparam logic [FMT_W-1:0] FMT_RGBA8   = 3'd1;
   localparam logic [FMT_W-1:0] FMT_565LE   = 3'd2;
   localparam logic [FMT_W-1:0] FMT_565BE   = 3'd3;
   localparam logic [FMT_W-1:0] FMT_332     = 3'd4;
   localparam logic [FMT_W-1:0] FMT_888     = 3'd5;
   localparam logic [FMT_W-1:0] FMT_BGR     = 3'd6;
   localparam logic [FMT_W-1:0] FMT_NONE    = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_FORMAT = 2'd1;

   typedef enum logic [1:0] {
      OP_ZERO,
      OP_COPY,
      OP_CONV
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [FMT_W-1:0]      sf;
      logic [FMT_W-1:0]      tf;
      logic [WORD_W-1:0]     word;
      logic [NBYTES_W-1:0]   nbytes;
      logic                  last;
   } cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0]     word;
      logic [NBYTES_W-1:0]   nbytes;
      logic                  last;
   } rsp_type;

endpackage

### rtl/pfc_fifo.sv
// Small synchronous queue with combinational head read.
module pfc_fifo #(
   parameter int unsigned DEPTH = pfc_pkg::QUEUE_DEPTH,
   parameter type T = pfc_pkg::cmd_type
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     wr_data,
   output logic full,
   input  logic pop,
   output T     rd_data,
   output logic empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   T                 mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue count overflow");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not shrink on pop");

endmodule

### rtl/pfc_front.sv
// Front end: format registers and classification of incoming pixels.
module pfc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfc_pkg::FMT_W-1:0]           csr_data,
   input  logic [pfc_pkg::WORD_W-1:0]          in_word,
   input  logic                                in_last,
   output pfc_pkg::cmd_type                    cmd
);

   logic [pfc_pkg::FMT_W-1:0]    src_fmt_ff;
   logic [pfc_pkg::FMT_W-1:0]    dst_fmt_ff;
   logic [pfc_pkg::NBYTES_W-1:0] src_bytes;
   logic [pfc_pkg::NBYTES_W-1:0] dst_bytes;
   logic [pfc_pkg::WORD_W-1:0]   copy_word;

   function automatic logic [pfc_pkg::NBYTES_W-1:0] fmt_bytes(
      input logic [pfc_pkg::FMT_W-1:0] f);
      logic [pfc_pkg::NBYTES_W-1:0] n;
      unique case (f)
         pfc_pkg::FMT_RGBA16P: n = 4'd8;
         pfc_pkg::FMT_RGBA8:   n = 4'd4;
         pfc_pkg::FMT_565LE,
         pfc_pkg::FMT_565BE:   n = 4'd2;
         pfc_pkg::FMT_332:     n = 4'd1;
         pfc_pkg::FMT_888,
         pfc_pkg::FMT_BGR:     n = 4'd3;
         default:              n = 4'd1;
      endcase
      return n;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff <= pfc_pkg::FMT_RGBA8;
         dst_fmt_ff <= pfc_pkg::FMT_RGBA8;
      end else if (csr_valid) begin
         if (csr_index == pfc_pkg::CSR_SOURCE_FORMAT) begin
            src_fmt_ff <= csr_data;
         end else if (csr_index == pfc_pkg::CSR_TARGET_FORMAT) begin
            dst_fmt_ff <= csr_data;
         end
      end
   end

   assign src_bytes = fmt_bytes(src_fmt_ff);
   assign dst_bytes = fmt_bytes(dst_fmt_ff);

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         copy_word[8*k +: 8] = (4'(k) < src_bytes) ? in_word[8*k +: 8] : 8'd0;
      end
   end

   always_comb begin
      cmd.sf     = src_fmt_ff;
      cmd.tf     = dst_fmt_ff;
      cmd.last   = in_last;
      cmd.nbytes = dst_bytes;
      if (src_fmt_ff == pfc_pkg::FMT_NONE || dst_fmt_ff == pfc_pkg::FMT_NONE) begin
         cmd.op     = pfc_pkg::OP_ZERO;
         cmd.word   = '0;
         cmd.nbytes = 4'd1;
      end else if (src_fmt_ff == dst_fmt_ff) begin
         cmd.op   = pfc_pkg::OP_COPY;
         cmd.word = copy_word;
      end else begin
         cmd.op   = pfc_pkg::OP_CONV;
         cmd.word = in_word;
      end
   end

endmodule

### rtl/pfc_back.sv
// Back end: decode, pipelined unpremultiply divider, encode and premultiply.
module pfc_back (
   input  logic              clock,
   input  logic              reset,
   input  pfc_pkg::cmd_type  cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output pfc_pkg::rsp_type  rsp,
   output logic              rsp_push,
   input  logic              rsp_full
);

   localparam int unsigned DIV_STAGES = pfc_pkg::DIV_STAGES;
   localparam int unsigned STEPS = 16 / DIV_STAGES;

   typedef struct packed {
      pfc_pkg::cmd_type   cmd;
      logic [31:0]        color;
      logic [8:0]         dvs;
      logic [2:0][15:0]   num;
      logic [2:0][7:0]    rem;
      logic [2:0][7:0]    quo;
   } stage_type;

   stage_type        st_ff  [DIV_STAGES+1];
   logic             vld_ff [DIV_STAGES+1];
   pfc_pkg::rsp_type res_ff, res_in;
   logic             res_vld_ff;
   logic             advance;
   stage_type        load;
   stage_type        tail;
   logic [31:0]      col;
   logic [8:0]       mul_m;
   logic [16:0]      pr, pg, pb, pa;

   function automatic logic [31:0] decode(input logic [2:0] f, input logic [63:0] w);
      logic [15:0] p;
      logic [31:0] c;
      p = '0;
      c = '0;
      unique case (f)
         pfc_pkg::FMT_RGBA16P: c = {w[63:56], 24'd0};
         pfc_pkg::FMT_RGBA8:   c = w[31:0];
         pfc_pkg::FMT_565LE,
         pfc_pkg::FMT_565BE: begin
            p = (f == pfc_pkg::FMT_565LE) ? w[15:0] : {w[7:0], w[15:8]};
            c = {8'hFF, p[4:0], p[4:2], p[10:5], p[10:9], p[15:11], p[15:13]};
         end
         pfc_pkg::FMT_332: begin
            c = {8'hFF, {4{w[1:0]}}, w[4:2], w[4:2], w[4:3], w[7:5], w[7:5], w[7:6]};
         end
         pfc_pkg::FMT_888:     c = {8'hFF, w[23:0]};
         pfc_pkg::FMT_BGR:     c = {8'hFF, w[7:0], w[15:8], w[23:16]};
         default:              c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [63:0] encode(input logic [2:0] f, input logic [31:0] c);
      logic [15:0] p;
      logic [63:0] w;
      p = {c[7:3], c[15:10], c[23:19]};
      unique case (f)
         pfc_pkg::FMT_RGBA8: w = {32'd0, c};
         pfc_pkg::FMT_565LE: w = {48'd0, p};
         pfc_pkg::FMT_565BE: w = {48'd0, p[7:0], p[15:8]};
         pfc_pkg::FMT_332:   w = {56'd0, c[7:5], c[15:13], c[23:22]};
         pfc_pkg::FMT_888:   w = {40'd0, c[23:0]};
         pfc_pkg::FMT_BGR:   w = {40'd0, c[7:0], c[15:8], c[23:16]};
         default:            w = '0;
      endcase
      return w;
   endfunction

   function automatic stage_type div_step(input stage_type s);
      stage_type o;
      logic [8:0] r9;
      o = s;
      for (int ln = 0; ln < 3; ln++) begin
         for (int st = 0; st < STEPS; st++) begin
            r9 = {o.rem[ln], o.num[ln][15]};
            o.num[ln] = {o.num[ln][14:0], 1'b0};
            if (r9 >= o.dvs) begin
               o.rem[ln] = 8'(r9 - o.dvs);
               o.quo[ln] = {o.quo[ln][6:0], 1'b1};
            end else begin
               o.rem[ln] = r9[7:0];
               o.quo[ln] = {o.quo[ln][6:0], 1'b0};
            end
         end
      end
      return o;
   endfunction

   assign advance  = !(res_vld_ff && rsp_full);
   assign cmd_pop  = advance && !cmd_empty;
   assign rsp_push = res_vld_ff && !rsp_full;
   assign rsp      = res_ff;

   always_comb begin
      load.cmd   = cmd;
      load.color = decode(cmd.sf, cmd.word);
      load.dvs   = {1'b0, cmd.word[63:56]} + 9'd1;
      load.num   = {cmd.word[47:32], cmd.word[31:16], cmd.word[15:0]};
      load.rem   = '0;
      load.quo   = '0;
   end

   always_comb begin
      tail = st_ff[DIV_STAGES];
      col  = tail.color;
      if (tail.cmd.sf == pfc_pkg::FMT_RGBA16P) begin
         col[23:0] = {tail.quo[2], tail.quo[1], tail.quo[0]};
      end
      mul_m = {1'b0, col[31:24]} + 9'd1;
      pr    = 17'(col[7:0])   * 17'(mul_m);
      pg    = 17'(col[15:8])  * 17'(mul_m);
      pb    = 17'(col[23:16]) * 17'(mul_m);
      pa    = 17'(mul_m) * 17'd255;
      res_in.last   = tail.cmd.last;
      res_in.nbytes = tail.cmd.nbytes;
      case (tail.cmd.op)
         pfc_pkg::OP_CONV: begin
            if (tail.cmd.tf == pfc_pkg::FMT_RGBA16P) begin
               res_in.word = {pa[15:0], pb[15:0], pg[15:0], pr[15:0]};
            end else begin
               res_in.word = encode(tail.cmd.tf, col);
            end
         end
         pfc_pkg::OP_COPY: res_in.word = tail.cmd.word;
         default:          res_in.word = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
         res_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= !cmd_empty;
         for (int k = 1; k <= DIV_STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         res_vld_ff <= vld_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0] <= load;
         for (int k = 1; k <= DIV_STAGES; k++) begin
            st_ff[k] <= div_step(st_ff[k-1]);
         end
         res_ff <= res_in;
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (res_vld_ff && rsp_full) |=> (res_vld_ff && $stable(res_ff)))
      else $error("result changed while stalled");

   a_pipe_moves: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DIV_STAGES] && advance) |=> res_vld_ff)
      else $error("pipeline lost a transaction");

   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      res_vld_ff |-> (res_ff.nbytes != 4'd0 && res_ff.nbytes <= 4'd8))
      else $error("byte count out of range");

endmodule

### rtl/pixel_format_converter_core.sv
// Pixel format converter core: one pixel per clock, unless stalled, between seven pixel formats.
//
// Input side is a queue: present req_in_word/req_in_last with push; the
// transaction is taken when push is high and full is low. Result side is a
// queue too: while empty is low the oldest result is on rsp_out_*; pop takes it.
// Source and target formats are written through the csr_ channel (index 0
// source, index 1 target), which is always ready; write only while idle.
// Throughput is one pixel per clock while the result side does not stall. A
// pixel passes the command queue, the decode load stage, the unpremultiply
// divider, which runs 16 quotient bits as 8 pipeline stages of 2 bits, the
// encode/premultiply stage and the result queue.
// When the receiver stalls, the result queue fills, the back-end pipeline
// freezes, then the command queue fills and full rises; nothing is dropped.
// Reset empties both queues and the pipeline and sets both formats to RGBA8.
module pixel_format_converter_core #(
   parameter int unsigned QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH,
   parameter int unsigned OUT_DEPTH   = pfc_pkg::OUT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [pfc_pkg::WORD_W-1:0]          req_in_word,
   input  logic                                req_in_last,
   output logic                                empty,
   input  logic                                pop,
   output logic [pfc_pkg::WORD_W-1:0]          rsp_out_word,
   output logic [pfc_pkg::NBYTES_W-1:0]        rsp_out_bytes,
   output logic                                rsp_out_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfc_pkg::FMT_W-1:0]           csr_data
);

   pfc_pkg::cmd_type front_cmd;
   pfc_pkg::cmd_type queue_cmd;
   logic             queue_empty;
   logic             queue_pop;
   pfc_pkg::rsp_type back_rsp;
   pfc_pkg::rsp_type out_rsp;
   logic             back_push;
   logic             out_full;

   pfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_word   (req_in_word),
      .in_last   (req_in_last),
      .cmd       (front_cmd)
   );

   pfc_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .T     (pfc_pkg::cmd_type)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_cmd),
      .full    (full),
      .pop     (queue_pop),
      .rd_data (queue_cmd),
      .empty   (queue_empty)
   );

   pfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (queue_cmd),
      .cmd_empty (queue_empty),
      .cmd_pop   (queue_pop),
      .rsp       (back_rsp),
      .rsp_push  (back_push),
      .rsp_full  (out_full)
   );

   pfc_fifo #(
      .DEPTH (OUT_DEPTH),
      .T     (pfc_pkg::rsp_type)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .wr_data (back_rsp),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_rsp),
      .empty   (empty)
   );

   assign rsp_out_word  = out_rsp.word;
   assign rsp_out_bytes = out_rsp.nbytes;
   assign rsp_out_last  = out_rsp.last;

endmodule
